### rtl/ordered_list_engine_core_defines.svh
// ----------------------------------------------------------------------------
// Ordered list engine assertion macros
// Shared concurrent assertion helpers for the ordered list engine RTL.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_CORE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define OLEC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define OLEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define OLEC_ASSERT(lbl, clk, rst_n, prop, msg)
`define OLEC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/olec_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list engine package
// Widths, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package olec_pkg;

    localparam int CAPACITY_DEFAULT = 64;
    localparam int DATA_W           = 32;
    localparam int OP_W             = 3;
    localparam int INDEX_W          = 6;
    localparam int COUNT_OUT_W      = 7;
    localparam int STATUS_W         = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_SORTED     = 3'd2;
    localparam logic [OP_W-1:0] OP_READ       = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_FRONT,
        MODE_BACK,
        MODE_SORT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       descending;
    } cell_ctrl_t;

endpackage

### rtl/ordered_list_engine_core.sv
// ----------------------------------------------------------------------------
// Ordered list engine core
// Bounded list of signed 32-bit entries kept in a chain of cells.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Push front, push
// back, clear and unused op codes go from idle straight to the commit state;
// done is registered from the commit state, and the next request can be
// taken at the edge that ends the done cycle. A sorted insert (one dropped on
// a full list included) and a read at index pass through a sweep state first,
// in which the first-match flag and the read data ripple through the cell
// chain one cell per clock until they reach the back cell. done is high for
// exactly one cycle with read_value, entry_count and status; the receiver
// cannot stall, so capture the result in that cycle. A new request may be
// issued in the same cycle the result is shown. Write descending_order
// through cfg_we/cfg_wdata only while idle.
module ordered_list_engine_core #(
    parameter int CAPACITY = olec_pkg::CAPACITY_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [olec_pkg::OP_W-1:0]             op,
    input  logic signed [olec_pkg::DATA_W-1:0]    value,
    input  logic [olec_pkg::INDEX_W-1:0]          index,
    input  logic                                  cfg_we,
    input  logic                                  cfg_wdata,
    output logic                                  done,
    output logic signed [olec_pkg::DATA_W-1:0]    read_value,
    output logic [olec_pkg::COUNT_OUT_W-1:0]      entry_count,
    output logic [olec_pkg::STATUS_W-1:0]         status
);
    import olec_pkg::*;
    `include "ordered_list_engine_core_defines.svh"

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int SWEEP_W = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_COMMIT
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [SWEEP_W-1:0]       sweep_cnt_reg;
    logic [SWEEP_W-1:0]       sweep_cnt_next;
    logic                     desc_reg;
    logic                     done_reg;
    logic signed [DATA_W-1:0] read_value_reg;
    logic signed [DATA_W-1:0] read_value_next;
    logic [COUNT_OUT_W-1:0]   entry_count_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;

    logic [OP_W-1:0]          op_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [INDEX_W-1:0]       index_reg;

    logic                     accept;
    logic                     is_insert;
    logic                     is_full;
    logic                     needs_sweep;
    cell_ctrl_t               cell_ctrl;

    logic signed [DATA_W-1:0] cell_data  [CAPACITY];
    logic                     cell_found [CAPACITY];
    logic signed [DATA_W-1:0] cell_rd    [CAPACITY];

    assign accept      = start && (state_reg == S_IDLE);
    assign busy        = (state_reg != S_IDLE);
    assign needs_sweep = (op == OP_SORTED) || (op == OP_READ);
    assign is_insert   = (op_reg == OP_PUSH_FRONT) || (op_reg == OP_PUSH_BACK) ||
                         (op_reg == OP_SORTED);
    assign is_full     = 32'(count_reg) >= 32'(CAPACITY);

    // Drive the cells: hold them except in the commit cycle of a live insert.
    always_comb
    begin
        cell_ctrl.descending = desc_reg;
        cell_ctrl.mode       = MODE_HOLD;
        if ((state_reg == S_COMMIT) && is_insert && !is_full)
        begin
            case (op_reg)
                OP_PUSH_FRONT: cell_ctrl.mode = MODE_FRONT;
                OP_PUSH_BACK:  cell_ctrl.mode = MODE_BACK;
                default:       cell_ctrl.mode = MODE_SORT;
            endcase
        end
    end

    // Chain of cells; the front cell takes the request value from the left.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_data;
        logic                     left_found;
        logic signed [DATA_W-1:0] left_rd;

        if (g == 0)
        begin : g_front
            assign left_data  = value_reg;
            assign left_found = 1'b0;
            assign left_rd    = '0;
        end
        else
        begin : g_inner
            assign left_data  = cell_data[g-1];
            assign left_found = cell_found[g-1];
            assign left_rd    = cell_rd[g-1];
        end

        olec_cell #(
            .POS   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .value      (value_reg),
            .index      (index_reg),
            .count      (count_reg),
            .left_data  (left_data),
            .left_found (left_found),
            .left_rd    (left_rd),
            .data       (cell_data[g]),
            .found      (cell_found[g]),
            .rd         (cell_rd[g])
        );
    end

    // Sequence the request and build the result in the commit cycle.
    always_comb
    begin
        state_next      = state_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        count_next      = count_reg;
        read_value_next = '0;
        status_next     = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sweep_cnt_next = '0;
                    state_next     = needs_sweep ? S_SWEEP : S_COMMIT;
                end
            end
            S_SWEEP:
            begin
                // Advance until the ripple has reached the back cell.
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == SWEEP_W'(CAPACITY - 1))
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                state_next = S_IDLE;
                if (is_insert)
                begin
                    if (is_full)
                        status_next = ST_FULL;
                    else
                        count_next = count_reg + 1'b1;
                end
                else if (op_reg == OP_READ)
                begin
                    if (32'(index_reg) < 32'(count_reg))
                        read_value_next = cell_rd[CAPACITY-1];
                    else
                        status_next = ST_RANGE;
                end
                else if (op_reg == OP_CLEAR)
                begin
                    count_next = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            sweep_cnt_reg   <= '0;
            desc_reg        <= 1'b0;
            done_reg        <= 1'b0;
            read_value_reg  <= '0;
            entry_count_reg <= '0;
            status_reg      <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sweep_cnt_reg <= sweep_cnt_next;
            done_reg      <= (state_reg == S_COMMIT);
            if (cfg_we)
                desc_reg <= cfg_wdata;
            if (state_reg == S_COMMIT)
            begin
                read_value_reg  <= read_value_next;
                entry_count_reg <= COUNT_OUT_W'(count_next);
                status_reg      <= status_next;
            end
        end
    end

    // Hold the request fields for the whole operation.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            value_reg <= value;
            index_reg <= index;
        end
    end

    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;
    assign status      = status_reg;

    `OLEC_ASSERT(a_accept_goes_busy, clk, rst_n, accept |=> busy, "request accepted but not busy")
    `OLEC_ASSERT(a_done_idle, clk, rst_n, done_reg |-> !busy, "result shown while still busy")
    `OLEC_ASSERT(a_count_bound, clk, rst_n, 32'(count_reg) <= 32'(CAPACITY), "count overflow")
    `OLEC_ASSERT(a_full_unchanged, clk, rst_n, (done_reg && status_reg == ST_FULL) |-> (32'(count_reg) == 32'(CAPACITY)), "full status with room left")
    `OLEC_ASSERT(a_range_zero, clk, rst_n, (done_reg && status_reg == ST_RANGE) |-> (read_value_reg == '0), "range error with nonzero data")
    `OLEC_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !done_reg, "result strobe during reset")

endmodule

### rtl/olec_cell.sv
// ----------------------------------------------------------------------------
// Ordered list engine cell
// One list position: holds its entry and forwards search results rightward.
// ----------------------------------------------------------------------------
module olec_cell #(
    parameter int POS   = 0,
    parameter int CNT_W = 7
) (
    input  logic                               clk,
    input  olec_pkg::cell_ctrl_t               ctrl,
    input  logic signed [olec_pkg::DATA_W-1:0] value,
    input  logic [olec_pkg::INDEX_W-1:0]       index,
    input  logic [CNT_W-1:0]                   count,
    input  logic signed [olec_pkg::DATA_W-1:0] left_data,
    input  logic                               left_found,
    input  logic signed [olec_pkg::DATA_W-1:0] left_rd,
    output logic signed [olec_pkg::DATA_W-1:0] data,
    output logic                               found,
    output logic signed [olec_pkg::DATA_W-1:0] rd
);
    import olec_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic signed [DATA_W-1:0] rd_reg;
    logic signed [DATA_W-1:0] rd_next;
    logic                     found_reg;
    logic                     found_next;
    logic                     occupied;
    logic                     at_count;
    logic                     match;
    logic                     hit;

    assign occupied = 32'(POS) < 32'(count);
    assign at_count = 32'(POS) == 32'(count);
    assign match    = occupied &&
                      (ctrl.descending ? (data_reg <= value) : (data_reg >= value));
    assign hit      = occupied && (32'(index) == 32'(POS));

    // Ripple the first-match flag and the selected entry one cell per cycle.
    assign found_next = left_found | match;
    assign rd_next    = hit ? data_reg : left_rd;

    always_comb
    begin
        unique case (ctrl.mode)
            MODE_FRONT: data_next = left_data;
            MODE_BACK:  data_next = at_count ? value : data_reg;
            MODE_SORT:
            begin
                if (left_found)
                    data_next = left_data;
                else if (match || at_count)
                    data_next = value;
                else
                    data_next = data_reg;
            end
            default:    data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        found_reg <= found_next;
        rd_reg    <= rd_next;
    end

    assign data  = data_reg;
    assign found = found_reg;
    assign rd    = rd_reg;

endmodule
